// ----- hdl/uds_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// uds_pkg : shared types and constants of the utf-8 stream decoder
// Item and result layouts, byte classes passed from the front end to the
// back end, and default queue depths.
// ----------------------------------------------------------------------------
package uds_pkg;

	// default queue depths
	localparam int FRONT_DEPTH_DEF = 2;
	localparam int OUT_DEPTH_DEF   = 2;

	// byte masks
	localparam logic [7:0] CONT_MASK  = 8'hC0;
	localparam logic [7:0] CONT_TAG   = 8'h80;
	localparam logic [7:0] LEAD2_LO   = 8'hC2;
	localparam logic [7:0] LEAD2_HI   = 8'hDF;
	localparam logic [7:0] LEAD4_HI   = 8'hF4;
	localparam logic [7:0] TAIL_MASK  = 8'h3F;
	localparam logic [1:0] CONT_PREFIX = 2'b10;

	// input item
	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_text;
	} in_item_t;

	// result item
	typedef struct packed {
		logic [20:0] codepoint;
		logic [2:0]  bytes_used;
		logic        raw_fallback;
		logic        last_of_run;
	} out_item_t;

	// class of one byte as seen without context
	typedef enum logic [2:0] {
		CL_END,
		CL_ASCII,
		CL_CONT,
		CL_LEAD,
		CL_BAD
	} byte_class_t;

	// classified item travelling from front to back
	typedef struct packed {
		logic [7:0]  data_byte;
		byte_class_t cls;
		logic [2:0]  seq_len;
	} cls_item_t;

endpackage : uds_pkg
`default_nettype wire

// ----- hdl/uds_fifo.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// uds_fifo : small register queue
// Holds up to DEPTH entries; head entry is visible while not empty.
// ----------------------------------------------------------------------------
module uds_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              push,
	input  wire  [WIDTH-1:0] din,
	output logic             full,
	input  wire              pop,
	output logic [WIDTH-1:0] dout,
	output logic             empty
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	// handshake
	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// fill level never exceeds depth
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH)) else $error("fifo over depth");
	// a transfer in with none out raises the fill level
	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		do_push && !do_pop |=> count_q == $past(count_q) + 1'b1)
		else $error("fifo count not incremented");
	// both pointers agree when empty or full
	a_ptr_match: assert property (@(posedge clk) disable iff (!arst_n)
		(empty || full) |-> wr_ptr_q == rd_ptr_q) else $error("fifo pointer mismatch");

endmodule : uds_fifo
`default_nettype wire

// ----- hdl/uds_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// uds_front : input side of the decoder
// Classifies each incoming byte and queues it for the back end.
// ----------------------------------------------------------------------------
module uds_front #(
	parameter int FRONT_DEPTH = uds_pkg::FRONT_DEPTH_DEF
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 push,
	input  uds_pkg::in_item_t   item,
	output logic                full,
	input  wire                 take,
	output uds_pkg::cls_item_t  head,
	output logic                avail
);
	import uds_pkg::*;

	cls_item_t                   cls_item;
	logic [$bits(cls_item_t)-1:0] head_bits;
	logic                        q_empty;

	// byte classification
	always_comb begin
		cls_item.data_byte = item.data_byte;
		cls_item.seq_len   = 3'd1;
		priority if (item.end_of_text) begin
			cls_item.cls = CL_END;
		end else if (!item.data_byte[7]) begin
			cls_item.cls = CL_ASCII;
		end else if ((item.data_byte & CONT_MASK) == CONT_TAG) begin
			cls_item.cls = CL_CONT;
		end else if (item.data_byte >= LEAD2_LO && item.data_byte <= LEAD2_HI) begin
			cls_item.cls     = CL_LEAD;
			cls_item.seq_len = 3'd2;
		end else if (item.data_byte[7:4] == 4'hE) begin
			cls_item.cls     = CL_LEAD;
			cls_item.seq_len = 3'd3;
		end else if (item.data_byte[7:4] == 4'hF && item.data_byte <= LEAD4_HI) begin
			cls_item.cls     = CL_LEAD;
			cls_item.seq_len = 3'd4;
		end else begin
			cls_item.cls = CL_BAD;
		end
	end

	// queue towards the back end
	uds_fifo #(
		.WIDTH ($bits(cls_item_t)),
		.DEPTH (FRONT_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (cls_item),
		.full   (full),
		.pop    (take),
		.dout   (head_bits),
		.empty  (q_empty)
	);

	assign head  = cls_item_t'(head_bits);
	assign avail = !q_empty;

endmodule : uds_front
`default_nettype wire

// ----- hdl/uds_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// uds_back : sequence tracker and result writer
// Holds the open sequence, writes at most one result per cycle into the
// result queue while it has room and replays a broken sequence byte by byte.
// ----------------------------------------------------------------------------
module uds_back #(
	parameter int OUT_DEPTH = uds_pkg::OUT_DEPTH_DEF
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  uds_pkg::cls_item_t  head,
	input  wire                 avail,
	output logic                take,
	output uds_pkg::out_item_t  result,
	output logic                empty,
	input  wire                 pop
);
	import uds_pkg::*;

	// sequence state
	logic [7:0] lead_q;
	logic [5:0] tail_q [3];
	logic [2:0] exp_len_q;
	logic [1:0] tail_cnt_q;
	logic [1:0] flush_pos_q;

	logic [7:0] lead_nxt;
	logic [2:0] exp_len_nxt;
	logic [1:0] tail_cnt_nxt;
	logic [1:0] flush_pos_nxt;
	logic       tail_we;

	logic       open_seq;
	logic       is_eot;
	logic       last_flush;
	logic       seq_done;
	logic       emit;
	logic       out_full;
	logic       fire;
	logic [5:0] new_tail;
	logic [20:0] assembled;
	out_item_t  res;
	logic [$bits(out_item_t)-1:0] res_bits;
	logic [$bits(out_item_t)-1:0] res_out_bits;

	assign open_seq   = (exp_len_q != 3'd0);
	assign is_eot     = (head.cls == CL_END);
	assign last_flush = (flush_pos_q == tail_cnt_q);
	assign seq_done   = ({1'b0, tail_cnt_q} + 3'd2) >= exp_len_q;
	assign new_tail   = head.data_byte[5:0];
	assign fire       = emit && !out_full;

	// code point from lead, buffered tails and the closing byte
	always_comb begin
		unique case (exp_len_q)
			3'd2:    assembled = {10'd0, lead_q[4:0], new_tail};
			3'd3:    assembled = {5'd0, lead_q[3:0], tail_q[0], new_tail};
			default: assembled = {lead_q[2:0], tail_q[0], tail_q[1], new_tail};
		endcase
	end

	// per-cycle decision
	always_comb begin
		emit          = 1'b0;
		take          = 1'b0;
		tail_we       = 1'b0;
		res           = '0;
		lead_nxt      = lead_q;
		exp_len_nxt   = exp_len_q;
		tail_cnt_nxt  = tail_cnt_q;
		flush_pos_nxt = flush_pos_q;
		if (avail) begin
			priority if (open_seq && (is_eot || head.cls != CL_CONT)) begin
				// broken sequence: replay lead then tails raw
				emit             = 1'b1;
				res.codepoint    = (flush_pos_q == 2'd0) ? {13'd0, lead_q}
					: {13'd0, CONT_PREFIX, tail_q[flush_pos_q - 2'd1]};
				res.bytes_used   = 3'd1;
				res.raw_fallback = 1'b1;
				res.last_of_run  = last_flush && (is_eot || head.cls == CL_LEAD);
				if (!out_full) begin
					take = last_flush && is_eot;
					if (last_flush) begin
						lead_nxt      = '0;
						exp_len_nxt   = '0;
						tail_cnt_nxt  = '0;
						flush_pos_nxt = '0;
					end else begin
						flush_pos_nxt = flush_pos_q + 2'd1;
					end
				end
			end else if (open_seq) begin
				// continuation byte of the open sequence
				emit             = seq_done;
				res.codepoint    = assembled;
				res.bytes_used   = exp_len_q;
				res.raw_fallback = 1'b0;
				res.last_of_run  = 1'b1;
				take             = !seq_done || !out_full;
				if (take) begin
					tail_we      = 1'b1;
					tail_cnt_nxt = tail_cnt_q + 2'd1;
					if (seq_done) begin
						lead_nxt     = '0;
						exp_len_nxt  = '0;
						tail_cnt_nxt = '0;
					end
				end
			end else begin
				// no sequence open
				unique case (head.cls)
					CL_END: begin
						take = 1'b1;
					end
					CL_ASCII: begin
						emit            = 1'b1;
						res.codepoint   = {13'd0, head.data_byte};
						res.bytes_used  = 3'd1;
						res.last_of_run = 1'b1;
						take            = !out_full;
					end
					CL_LEAD: begin
						take         = 1'b1;
						lead_nxt     = head.data_byte;
						exp_len_nxt  = head.seq_len;
						tail_cnt_nxt = '0;
					end
					default: begin
						emit             = 1'b1;
						res.codepoint    = {13'd0, head.data_byte};
						res.bytes_used   = 3'd1;
						res.raw_fallback = 1'b1;
						res.last_of_run  = 1'b1;
						take             = !out_full;
					end
				endcase
			end
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_q      <= '0;
			exp_len_q   <= '0;
			tail_cnt_q  <= '0;
			flush_pos_q <= '0;
		end else begin
			lead_q      <= lead_nxt;
			exp_len_q   <= exp_len_nxt;
			tail_cnt_q  <= tail_cnt_nxt;
			flush_pos_q <= flush_pos_nxt;
		end
	end

	// buffered continuation payloads
	always_ff @(posedge clk) begin
		if (tail_we && !seq_done) begin
			tail_q[tail_cnt_q] <= new_tail;
		end
	end

	// result queue
	assign res_bits = res;

	uds_fifo #(
		.WIDTH ($bits(out_item_t)),
		.DEPTH (OUT_DEPTH)
	) u_out_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (fire),
		.din    (res_bits),
		.full   (out_full),
		.pop    (pop),
		.dout   (res_out_bits),
		.empty  (empty)
	);

	assign result = out_item_t'(res_out_bits);

	// an open sequence always has room for one more tail before completing
	a_tail_bound: assert property (@(posedge clk) disable iff (!arst_n)
		open_seq |-> ({1'b0, tail_cnt_q} + 3'd1) < exp_len_q)
		else $error("tail count reached sequence length");
	// replay position stays within the buffered bytes of an open sequence
	a_flush_open: assert property (@(posedge clk) disable iff (!arst_n)
		flush_pos_q != 2'd0 |-> open_seq && flush_pos_q <= tail_cnt_q)
		else $error("replay outside open sequence");
	// no sequence length of one is ever held
	a_len_valid: assert property (@(posedge clk) disable iff (!arst_n)
		exp_len_q != 3'd1) else $error("bad sequence length");
	// an item leaves the front queue only when one is there
	a_take_avail: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> avail) else $error("transfer from empty front queue");

endmodule : uds_back
`default_nettype wire

// ----- hdl/utf8_stream_decoder_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_stream_decoder_unit : utf-8 byte stream to code point decoder
// Front end classifies bytes into a short queue; back end tracks sequences
// and writes results into an output queue.
// ----------------------------------------------------------------------------
// One byte is taken per cycle while each byte gives at most one result and
// the result queue has room; a sequence broken by a non-continuation byte or
// an end item is replayed at one result per cycle (up to four results for one
// byte), since the back end writes a single result per cycle into the result
// queue. A result passes through both queues. Both sides stall on their own:
// full rises only when the front queue (FRONT_DEPTH items) fills, and results
// wait in the result queue (OUT_DEPTH entries) until popped.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_unit #(
	parameter int FRONT_DEPTH = uds_pkg::FRONT_DEPTH_DEF,
	parameter int OUT_DEPTH   = uds_pkg::OUT_DEPTH_DEF
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 push,
	input  uds_pkg::in_item_t   item,
	output logic                full,
	output logic                empty,
	input  wire                 pop,
	output uds_pkg::out_item_t  result
);
	import uds_pkg::*;

	cls_item_t head;
	logic      avail;
	logic      take;

	// byte classification and input queue
	uds_front #(
		.FRONT_DEPTH (FRONT_DEPTH)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.item   (item),
		.full   (full),
		.take   (take),
		.head   (head),
		.avail  (avail)
	);

	// sequence handling and result queue
	uds_back #(
		.OUT_DEPTH (OUT_DEPTH)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.avail  (avail),
		.take   (take),
		.result (result),
		.empty  (empty),
		.pop    (pop)
	);

endmodule : utf8_stream_decoder_unit
`default_nettype wire
